FILE: hdl/aod_pkg.sv
// shared widths, register indexes, reset values and types for the onset detector
package aod_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 16;
  localparam int GUARD_BITS  = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int TDATA_IN_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int TDATA_OUT_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS  = 32;

  // 1.0 in the envelope format
  localparam logic [SAMPLE_BITS-1:0] UNITY = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_ATTACK  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_RELEASE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_ATTACK  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_RELEASE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUARD        = 3'd5;

  // reset values
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST    = SAMPLE_BITS'(838861);
  localparam logic [COEFF_BITS-1:0]  FAST_ATTACK_RST  = COEFF_BITS'(65421);
  localparam logic [COEFF_BITS-1:0]  FAST_RELEASE_RST = COEFF_BITS'(65527);
  localparam logic [COEFF_BITS-1:0]  SLOW_ATTACK_RST  = COEFF_BITS'(65263);
  localparam logic [COEFF_BITS-1:0]  SLOW_RELEASE_RST = COEFF_BITS'(65531);
  localparam logic [GUARD_BITS-1:0]  GUARD_RST        = GUARD_BITS'(2400);

  typedef logic [SAMPLE_BITS-1:0] env_t;
  typedef logic [COEFF_BITS-1:0]  coeff_t;

  // settings seen by the trigger stage
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] threshold;
    logic [GUARD_BITS-1:0]  guard_samples;
  } aod_trig_cfg_t;

endpackage

FILE: hdl/aod_follower.sv
// one asymmetric one-pole envelope follower update
module aod_follower (
  input  aod_pkg::env_t   env,
  input  aod_pkg::env_t   mag,
  input  aod_pkg::coeff_t attack_coeff,
  input  aod_pkg::coeff_t release_coeff,
  output aod_pkg::env_t   env_next
);
  import aod_pkg::*;

  logic                                  attack;
  logic signed [SAMPLE_BITS:0]           diff;
  logic        [SAMPLE_BITS-1:0]         base;
  logic signed [COEFF_BITS:0]            coeff;
  logic signed [SAMPLE_BITS+COEFF_BITS+1:0] prod;
  logic signed [SAMPLE_BITS+COEFF_BITS+1:0] scaled;

  // attack: mag + floor(c*(env-mag)/2^k), release: floor(c*env/2^k)
  assign attack = mag > env;
  assign diff   = attack ? ($signed({1'b0, env}) - $signed({1'b0, mag}))
                         : $signed({1'b0, env});
  assign base   = attack ? mag : '0;
  assign coeff  = $signed({1'b0, attack ? attack_coeff : release_coeff});
  assign prod   = diff * coeff;
  assign scaled = prod >>> COEFF_BITS;
  assign env_next = scaled[SAMPLE_BITS-1:0] + base;

endmodule

FILE: hdl/aod_trigger.sv
// rising-edge threshold detect with retrigger guard countdown
module aod_trigger (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  aod_pkg::aod_trig_cfg_t         cfg,
  input  aod_pkg::env_t                  fast_env,
  input  aod_pkg::env_t                  slow_env,
  output logic                           onset,
  output aod_pkg::env_t                  velocity
);
  import aod_pkg::*;

  logic                  was_above;
  logic [GUARD_BITS-1:0] guard_count;
  logic [GUARD_BITS-1:0] guard_count_next;
  logic                  above;

  assign above = fast_env > cfg.threshold;

  always_comb begin
    onset = 1'b0;
    guard_count_next = guard_count;
    if (guard_count != '0) begin
      guard_count_next = guard_count - GUARD_BITS'(1);
    end else begin
      onset = above && !was_above;
      guard_count_next = onset ? cfg.guard_samples : '0;
    end
  end

  assign velocity = !onset ? '0 : ((slow_env > UNITY) ? UNITY : slow_env);

  always_ff @(posedge clk) begin
    if (rst) begin
      was_above   <= 1'b0;
      guard_count <= '0;
    end else if (step) begin
      was_above   <= above;
      guard_count <= guard_count_next;
    end
  end

endmodule

FILE: hdl/audio_onset_detector_core.sv
// top level of the onset detector: config registers, pipeline and handshakes
//
// Usage: audio samples enter on the s_axis channel, one signed sample per beat
// in tdata. Every sample produces exactly one result beat on m_axis: tuser
// carries the onset flag, tdata the velocity (slow envelope clamped to 1.0 on
// an onset, zero otherwise).
// Settings are written on the cfg channel (index, data); cfg_ready is always
// high. Write them only while no sample is in flight.
// Pipeline: input register (rectified magnitude), envelope stage (one multiply
// and add per follower, the envelope registers are the stage output), trigger
// stage feeding the result register. An accepted sample goes from the input
// register through the envelope registers into the result register, where it
// is offered on m_axis. One sample per cycle is sustained while m_axis_tready
// stays high; the envelope feedback through each multiplier sets that limit.
// When m_axis_tready is low the result holds, the stages behind it fill and
// s_axis_tready drops once all three registers are full; nothing is lost.
// Reset clears the envelopes, guard count and valid flags and loads the
// default settings.
module audio_onset_detector_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [aod_pkg::TDATA_IN_BITS-1:0]   s_axis_tdata,  // [23:0] sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [aod_pkg::TDATA_OUT_BITS-1:0]  m_axis_tdata,  // [23:0] velocity
  output logic                                m_axis_tuser,  // [0] onset
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aod_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [aod_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import aod_pkg::*;

  // settings
  logic [SAMPLE_BITS-1:0] threshold;
  coeff_t                 fast_attack_coeff;
  coeff_t                 fast_release_coeff;
  coeff_t                 slow_attack_coeff;
  coeff_t                 slow_release_coeff;
  logic [GUARD_BITS-1:0]  guard_samples;
  aod_trig_cfg_t          trig_cfg;

  // pipeline
  logic                   mag_valid;
  env_t                   mag;
  logic                   env_valid;
  env_t                   fast_env;
  env_t                   slow_env;
  env_t                   fast_env_next;
  env_t                   slow_env_next;
  logic                   out_valid;
  logic                   out_onset;
  env_t                   out_velocity;
  logic                   trig_onset;
  env_t                   trig_velocity;

  logic [SAMPLE_BITS-1:0] sample_in;
  env_t                   mag_next;
  logic                   out_free;
  logic                   adv_trig;
  logic                   mid_free;
  logic                   adv_env;
  logic                   in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold          <= THRESHOLD_RST;
      fast_attack_coeff  <= FAST_ATTACK_RST;
      fast_release_coeff <= FAST_RELEASE_RST;
      slow_attack_coeff  <= SLOW_ATTACK_RST;
      slow_release_coeff <= SLOW_RELEASE_RST;
      guard_samples      <= GUARD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD:    threshold          <= cfg_data[SAMPLE_BITS-1:0];
        REG_FAST_ATTACK:  fast_attack_coeff  <= cfg_data[COEFF_BITS-1:0];
        REG_FAST_RELEASE: fast_release_coeff <= cfg_data[COEFF_BITS-1:0];
        REG_SLOW_ATTACK:  slow_attack_coeff  <= cfg_data[COEFF_BITS-1:0];
        REG_SLOW_RELEASE: slow_release_coeff <= cfg_data[COEFF_BITS-1:0];
        REG_GUARD:        guard_samples      <= cfg_data[GUARD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign trig_cfg.threshold     = threshold;
  assign trig_cfg.guard_samples = guard_samples;

  // stage advance chain from the output side back
  assign out_free      = !out_valid || m_axis_tready;
  assign adv_trig      = env_valid && out_free;
  assign mid_free      = !env_valid || adv_trig;
  assign adv_env       = mag_valid && mid_free;
  assign s_axis_tready = !mag_valid || adv_env;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // rectify on the way in; the most negative sample maps to exactly 1.0
  assign sample_in = s_axis_tdata[SAMPLE_BITS-1:0];
  assign mag_next  = sample_in[SAMPLE_BITS-1] ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (s_axis_tready) begin
      mag_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mag <= mag_next;
    end
  end

  aod_follower u_fast (
    .env           (fast_env),
    .mag           (mag),
    .attack_coeff  (fast_attack_coeff),
    .release_coeff (fast_release_coeff),
    .env_next      (fast_env_next)
  );

  aod_follower u_slow (
    .env           (slow_env),
    .mag           (mag),
    .attack_coeff  (slow_attack_coeff),
    .release_coeff (slow_release_coeff),
    .env_next      (slow_env_next)
  );

  // envelope registers double as the stage output
  always_ff @(posedge clk) begin
    if (rst) begin
      env_valid <= 1'b0;
      fast_env  <= '0;
      slow_env  <= '0;
    end else begin
      if (mid_free) begin
        env_valid <= mag_valid;
      end
      if (adv_env) begin
        fast_env <= fast_env_next;
        slow_env <= slow_env_next;
      end
    end
  end

  aod_trigger u_trigger (
    .clk      (clk),
    .rst      (rst),
    .step     (adv_trig),
    .cfg      (trig_cfg),
    .fast_env (fast_env),
    .slow_env (slow_env),
    .onset    (trig_onset),
    .velocity (trig_velocity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= env_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_trig) begin
      out_onset    <= trig_onset;
      out_velocity <= trig_velocity;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_onset;
  assign m_axis_tdata  = TDATA_OUT_BITS'(out_velocity);

endmodule
